FILE: design/kda_pkg.sv
package kda_pkg;

  // Key count and counter width
  localparam int NUM_KEYS    = 3;
  localparam int COUNT_WIDTH = 16;

  // Field widths of the request and result channels
  localparam int KEY_BITS = 3;
  localparam int EN_W     = 3 * KEY_BITS;
  localparam int TICK_W   = 13;
  localparam int CFG_IDX_W = 3;

  // Remainder search runs one dividend bit per step
  localparam int DIV_STEPS = COUNT_WIDTH;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_BASE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IVL_BASE   = 3'd4;

  // Per-key enable bit positions inside a key's three-bit group
  localparam int EN_PRESS   = 0;
  localparam int EN_RELEASE = 1;
  localparam int EN_REPEAT  = 2;

  typedef logic [COUNT_WIDTH-1:0]            count_t;
  typedef logic [TICK_W-1:0]                 tick_t;
  typedef logic [NUM_KEYS-1:0][TICK_W-1:0]   tick_arr_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

FILE: design/kda_cfg.sv
module kda_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kda_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kda_pkg::TICK_W-1:0]    cfg_data,
  output logic [kda_pkg::EN_W-1:0]      enables,
  output kda_pkg::tick_arr_t            trig_ticks,
  output kda_pkg::tick_arr_t            ivl_ticks
);
  import kda_pkg::*;

  logic [EN_W-1:0] enables_r;
  tick_arr_t       trig_r;
  tick_arr_t       ivl_r;
  logic            wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  // Decode the index and update the addressed register; other indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enables_r <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        trig_r[k] <= TICK_W'(1);
        ivl_r[k]  <= TICK_W'(1);
      end
    end else if (wr) begin
      if (cfg_index == REG_ENABLES) begin
        enables_r <= cfg_data[EN_W-1:0];
      end
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (cfg_index == REG_TRIG_BASE + CFG_IDX_W'(k)) begin
          trig_r[k] <= cfg_data;
        end
        if (cfg_index == REG_IVL_BASE + CFG_IDX_W'(k)) begin
          ivl_r[k] <= cfg_data;
        end
      end
    end
  end

  assign enables    = enables_r;
  assign trig_ticks = trig_r;
  assign ivl_ticks  = ivl_r;

endmodule

FILE: design/kda_ctrl.sv
module kda_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kda_pkg::dp_status_t status,
  output kda_pkg::ctrl_cmd_t  cmd
);
  import kda_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Sequence one tick: take the request, run the remainder steps, commit
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Commit only into a free output register
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> status.out_free) else $error("commit into busy output");

  // Commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step, cmd.commit})) else $error("overlapping commands");

  // A load is followed by the first remainder step
  a_load_then_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.step) else $error("load not followed by step");

endmodule

FILE: design/kda_datapath.sv
module kda_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  kda_pkg::ctrl_cmd_t           cmd,
  output kda_pkg::dp_status_t          status,
  input  logic [kda_pkg::KEY_BITS-1:0] in_pin_levels,
  input  logic [kda_pkg::EN_W-1:0]     enables,
  input  kda_pkg::tick_arr_t           trig_ticks,
  input  kda_pkg::tick_arr_t           ivl_ticks,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [kda_pkg::KEY_BITS-1:0] out_press_events,
  output logic [kda_pkg::KEY_BITS-1:0] out_release_events,
  output logic [kda_pkg::KEY_BITS-1:0] out_repeat_events,
  output logic [kda_pkg::KEY_BITS-1:0] out_held_keys
);
  import kda_pkg::*;

  // Per-key state
  logic   [NUM_KEYS-1:0] flag_r, flag_nxt;
  count_t                count_r [NUM_KEYS];
  count_t                count_nxt [NUM_KEYS];

  // Per-tick working registers
  logic   [KEY_BITS-1:0] pins_r;
  count_t                c_r   [NUM_KEYS];
  count_t                dvd_r [NUM_KEYS];
  tick_t                 rem_r [NUM_KEYS];
  tick_t                 rem_nxt [NUM_KEYS];

  // Output register
  logic                  out_valid_r;
  logic   [KEY_BITS-1:0] press_r, release_r, repeat_r, held_r;
  logic   [KEY_BITS-1:0] press_nxt, release_nxt, repeat_nxt, held_nxt;

  tick_t                 trig_eff [NUM_KEYS];
  tick_t                 ivl_eff  [NUM_KEYS];

  // A zero trigger or interval acts as one
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      trig_eff[k] = (trig_ticks[k] == '0) ? TICK_W'(1) : trig_ticks[k];
      ivl_eff[k]  = (ivl_ticks[k] == '0) ? TICK_W'(1) : ivl_ticks[k];
    end
  end

  // One restoring remainder step per key: shift in a dividend bit, subtract if it fits
  always_comb begin
    logic [TICK_W:0] sh;
    sh = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      sh = {rem_r[k], dvd_r[k][COUNT_WIDTH-1]};
      if (sh >= {1'b0, ivl_eff[k]}) begin
        sh = sh - {1'b0, ivl_eff[k]};
      end
      rem_nxt[k] = sh[TICK_W-1:0];
    end
  end

  // Load the tick, then advance the remainder search
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pins_r <= in_pin_levels;
      for (int k = 0; k < NUM_KEYS; k++) begin
        c_r[k]   <= count_r[k] + COUNT_WIDTH'(1);
        dvd_r[k] <= count_r[k] + COUNT_WIDTH'(1) - COUNT_WIDTH'(trig_eff[k]);
        rem_r[k] <= '0;
      end
    end else if (cmd.step) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        dvd_r[k] <= {dvd_r[k][COUNT_WIDTH-2:0], 1'b0};
        rem_r[k] <= rem_nxt[k];
      end
    end
  end

  // Work out each key's next state and its events
  always_comb begin
    logic [2:0] en;
    logic       rep;
    en          = '0;
    rep         = 1'b0;
    press_nxt   = '0;
    release_nxt = '0;
    repeat_nxt  = '0;
    held_nxt    = '0;
    flag_nxt    = flag_r;
    for (int k = 0; k < NUM_KEYS; k++) begin
      count_nxt[k] = count_r[k];
      en  = enables[3*k +: 3];
      rep = 1'b0;
      if (!pins_r[k]) begin
        if (!flag_r[k]) begin
          flag_nxt[k] = 1'b1;
        end else if (count_r[k] != '1) begin
          count_nxt[k] = c_r[k];
          if (c_r[k] == COUNT_WIDTH'(1)) begin
            press_nxt[k] = en[EN_PRESS];
          end
          if (c_r[k] == COUNT_WIDTH'(trig_eff[k])) begin
            rep = 1'b1;
          end else if (c_r[k] > COUNT_WIDTH'(trig_eff[k]) && rem_r[k] == '0) begin
            rep = 1'b1;
          end
          repeat_nxt[k] = rep & en[EN_REPEAT];
        end
      end else if (flag_r[k]) begin
        flag_nxt[k] = 1'b0;
        if (count_r[k] != '0) begin
          count_nxt[k]   = '0;
          release_nxt[k] = en[EN_RELEASE];
        end
      end
      held_nxt[k] = (count_nxt[k] != '0);
    end
  end

  // Commit key state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        count_r[k] <= '0;
      end
    end else if (cmd.commit) begin
      flag_r <= flag_nxt;
      for (int k = 0; k < NUM_KEYS; k++) begin
        count_r[k] <= count_nxt[k];
      end
    end
  end

  // Output register: fill on commit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      press_r   <= press_nxt;
      release_r <= release_nxt;
      repeat_r  <= repeat_nxt;
      held_r    <= held_nxt;
    end
  end

  assign status.out_free    = !out_valid_r || !out_stall;
  assign out_valid          = out_valid_r;
  assign out_press_events   = press_r;
  assign out_release_events = release_r;
  assign out_repeat_events  = repeat_r;
  assign out_held_keys      = held_r;

  // A key that has counted is still debounced
  a_count_flag: assert property (@(posedge clk) disable iff (!rst_n)
    ((count_r[0] != '0) |-> flag_r[0])) else $error("key count without debounce flag");

  // A press leaves the key held
  a_press_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_press_events & ~out_held_keys) == '0))
    else $error("press event on key not held");

  // A release leaves the key not held
  a_release_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_release_events & out_held_keys) == '0))
    else $error("release event on held key");

endmodule

FILE: design/key_debounce_autorepeat.sv
// Three-key debounce with press, release and auto-repeat events. Each request
// is one scan tick carrying the active-low pin levels; each tick yields exactly
// one result. An accepted tick is loaded, runs 16 remainder steps and is then
// committed to the output register; the commit waits while a stalled result
// still occupies that register. The next request is taken on the cycle after
// the commit, so a new tick is not accepted while one is in flight.
// The 16 steps are the bit-serial remainder search that finds the repeat phase,
// one bit of the 16-bit held count per cycle, run on all keys in parallel. A
// finished result waits in the output register while the next tick is already
// accepted. Configuration writes are always ready and must only be issued while
// no tick is in flight.
module key_debounce_autorepeat (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kda_pkg::KEY_BITS-1:0]  in_pin_levels,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kda_pkg::KEY_BITS-1:0]  out_press_events,
  output logic [kda_pkg::KEY_BITS-1:0]  out_release_events,
  output logic [kda_pkg::KEY_BITS-1:0]  out_repeat_events,
  output logic [kda_pkg::KEY_BITS-1:0]  out_held_keys,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kda_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kda_pkg::TICK_W-1:0]    cfg_data
);
  import kda_pkg::*;

  logic [EN_W-1:0] enables;
  tick_arr_t       trig_ticks;
  tick_arr_t       ivl_ticks;
  ctrl_cmd_t       cmd;
  dp_status_t      status;

  kda_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .enables    (enables),
    .trig_ticks (trig_ticks),
    .ivl_ticks  (ivl_ticks)
  );

  kda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  kda_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_pin_levels      (in_pin_levels),
    .enables            (enables),
    .trig_ticks         (trig_ticks),
    .ivl_ticks          (ivl_ticks),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_press_events   (out_press_events),
    .out_release_events (out_release_events),
    .out_repeat_events  (out_repeat_events),
    .out_held_keys      (out_held_keys)
  );

endmodule
